// ===== hdl/bli_pkg.sv =====
// Shared types and constants for the breakpoint linear interpolator.
// No dependencies; the top level and the divider stage import it.
package bli_pkg;

	localparam int BP_W       = 23;
	localparam int IN_W       = 24;
	localparam int FRAC_W     = 17;
	localparam int SEG_W      = 3;
	localparam int MAX_POINTS = 4;
	localparam int IDX_W      = 2;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_BP0 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BP1 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BP2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BP3 = 2'd3;

	localparam logic [BP_W-1:0] BP0_RESET = 23'd25600;
	localparam logic [BP_W-1:0] BP1_RESET = 23'd51200;
	localparam logic [BP_W-1:0] BP2_RESET = 23'd153600;
	localparam logic [BP_W-1:0] BP3_RESET = 23'd307200;

	typedef enum logic [1:0] {
		MODE_LOW,
		MODE_HIGH,
		MODE_FLAT,
		MODE_INTERP
	} mode_t;

	// Sideband that rides along the divider unchanged.
	typedef struct packed {
		mode_t                   mode;
		logic [SEG_W-1:0]        seg;
		logic signed [IN_W-1:0]  s_lo;
		logic signed [IN_W:0]    diff;
	} side_t;

endpackage

// ===== hdl/bli_div_stage.sv =====
// One restoring division step with its pipeline register.
// Depends on bli_pkg for widths and the sideband struct.
module bli_div_stage #(
	parameter int FRACTION_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       cur_valid,
	input  logic [bli_pkg::BP_W-1:0]   cur_rem,
	input  logic [bli_pkg::BP_W-1:0]   cur_span,
	input  logic [FRACTION_BITS-1:0]   cur_quo,
	input  bli_pkg::side_t             cur_side,
	output logic                       nxt_valid,
	output logic [bli_pkg::BP_W-1:0]   nxt_rem,
	output logic [bli_pkg::BP_W-1:0]   nxt_span,
	output logic [FRACTION_BITS-1:0]   nxt_quo,
	output bli_pkg::side_t             nxt_side
);
	import bli_pkg::*;

	logic [BP_W:0]            trial;
	logic [BP_W:0]            sub;
	logic                     ge;
	logic [BP_W-1:0]          rem_d;
	logic                     valid_q;
	logic [BP_W-1:0]          rem_q;
	logic [BP_W-1:0]          span_q;
	logic [FRACTION_BITS-1:0] quo_q;
	side_t                    side_q;

	// remainder stays below span, so the doubled value fits in BP_W+1 bits
	assign trial = {cur_rem, 1'b0};
	assign sub   = trial - {1'b0, cur_span};
	assign ge    = trial >= {1'b0, cur_span};
	assign rem_d = ge ? sub[BP_W-1:0] : trial[BP_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= cur_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= rem_d;
			span_q <= cur_span;
			quo_q  <= {cur_quo[FRACTION_BITS-2:0], ge};
			side_q <= cur_side;
		end
	end

	assign nxt_valid = valid_q;
	assign nxt_rem   = rem_q;
	assign nxt_span  = span_q;
	assign nxt_quo   = quo_q;
	assign nxt_side  = side_q;

endmodule

// ===== hdl/breakpoint_linear_interpolator_unit.sv =====
// Top level of the breakpoint linear interpolator: segment search, span setup,
// pipelined restoring divider, multiply and final add. Uses bli_pkg, bli_div_stage.
//
//   channel | handshake            | payload
//   --------+----------------------+----------------------------------------
//   in      | in_valid / in_stall  | speed_in, stat_0 .. stat_3
//   out     | out_valid / out_stall| value_out, fraction_out, segment_out
//   cfg     | cfg_we (no wait)     | cfg_index, cfg_data
//
// One beat enters per cycle while the output is not stalled; a result passes stages 1 and 2,
// then the divider, which retires one quotient bit per stage, then stages 3 and 4.
// Reset clears every valid bit and loads the breakpoint defaults; payload is not reset.
// A stalled output beat freezes the whole pipeline and raises in_stall; nothing is
// dropped or repeated, and the pipeline resumes on the cycle the stall drops.
module breakpoint_linear_interpolator_unit #(
	parameter int NUM_POINTS    = 4,
	parameter int FRACTION_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [bli_pkg::IN_W-1:0]      speed_in,
	input  logic signed [bli_pkg::IN_W-1:0]      stat_0,
	input  logic signed [bli_pkg::IN_W-1:0]      stat_1,
	input  logic signed [bli_pkg::IN_W-1:0]      stat_2,
	input  logic signed [bli_pkg::IN_W-1:0]      stat_3,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [bli_pkg::IN_W-1:0]      value_out,
	output logic [bli_pkg::FRAC_W-1:0]           fraction_out,
	output logic [bli_pkg::SEG_W-1:0]            segment_out,
	input  logic                                 cfg_we,
	input  logic [bli_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [bli_pkg::BP_W-1:0]             cfg_data
);
	import bli_pkg::*;

	localparam int FB     = FRACTION_BITS;
	localparam int PROD_W = FB + IN_W + 2;
	localparam logic [SEG_W-1:0] SEG_TOP  = SEG_W'(NUM_POINTS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_POINTS - 1);
	localparam logic [FB:0]      FRAC_ONE = {1'b1, {FB{1'b0}}};

	// global advance: hold everything while the output beat is refused
	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// ---------------- breakpoint registers ----------------
	logic [BP_W-1:0] bp_q [0:MAX_POINTS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bp_q[0] <= BP0_RESET;
			bp_q[1] <= BP1_RESET;
			bp_q[2] <= BP2_RESET;
			bp_q[3] <= BP3_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BP0: bp_q[0] <= cfg_data;
				REG_BP1: bp_q[1] <= cfg_data;
				REG_BP2: bp_q[2] <= cfg_data;
				REG_BP3: bp_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- stage 1: clamp and segment search ----------------
	logic [BP_W-1:0]        speed_c;
	logic [SEG_W-1:0]       seg_c;
	logic                   valid_s1;
	logic [BP_W-1:0]        speed_s1;
	logic [SEG_W-1:0]       seg_s1;
	logic signed [IN_W-1:0] stat_s1 [0:MAX_POINTS-1];

	// negative speed counts as zero
	assign speed_c = speed_in[IN_W-1] ? '0 : speed_in[BP_W-1:0];

	// first breakpoint strictly above the speed; scan from the top so the lowest wins
	always_comb begin
		seg_c = SEG_TOP;
		for (int i = NUM_POINTS - 1; i >= 0; i--) begin
			if (speed_c < bp_q[i]) begin
				seg_c = SEG_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			speed_s1   <= speed_c;
			seg_s1     <= seg_c;
			stat_s1[0] <= stat_0;
			stat_s1[1] <= stat_1;
			stat_s1[2] <= stat_2;
			stat_s1[3] <= stat_3;
		end
	end

	// ---------------- stage 2: pick neighbors, form remainder and span ----------------
	logic [IDX_W-1:0]       idx_hi;
	logic [IDX_W-1:0]       idx_lo;
	logic [BP_W-1:0]        bp_lo;
	logic [BP_W-1:0]        bp_hi;
	side_t                  side_c;
	logic [BP_W-1:0]        rem_c;
	logic [BP_W-1:0]        span_c;
	logic                   valid_s2;
	logic [BP_W-1:0]        rem_s2;
	logic [BP_W-1:0]        span_s2;
	side_t                  side_s2;

	assign idx_hi = seg_s1[IDX_W-1:0];
	assign idx_lo = IDX_W'(seg_s1 - SEG_W'(1));
	assign bp_lo  = bp_q[idx_lo];
	assign bp_hi  = bp_q[idx_hi];

	always_comb begin
		side_c.seg  = seg_s1;
		side_c.diff = '0;
		rem_c       = '0;
		span_c      = BP_W'(1);
		if (seg_s1 == '0) begin
			side_c.mode = MODE_LOW;
			side_c.s_lo = stat_s1[0];
		end else if (seg_s1 == SEG_TOP) begin
			side_c.mode = MODE_HIGH;
			side_c.s_lo = stat_s1[LAST_IDX];
		end else if (bp_hi <= bp_lo) begin
			// empty or inverted span: hold the lower stat
			side_c.mode = MODE_FLAT;
			side_c.s_lo = stat_s1[idx_lo];
		end else begin
			side_c.mode = MODE_INTERP;
			side_c.s_lo = stat_s1[idx_lo];
			side_c.diff = {stat_s1[idx_hi][IN_W-1], stat_s1[idx_hi]}
				- {stat_s1[idx_lo][IN_W-1], stat_s1[idx_lo]};
			rem_c       = speed_s1 - bp_lo;
			span_c      = bp_hi - bp_lo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s2  <= rem_c;
			span_s2 <= span_c;
			side_s2 <= side_c;
		end
	end

	// ---------------- divider: one quotient bit per stage ----------------
	logic            dv_valid [0:FB];
	logic [BP_W-1:0] dv_rem   [0:FB];
	logic [BP_W-1:0] dv_span  [0:FB];
	logic [FB-1:0]   dv_quo   [0:FB];
	side_t           dv_side  [0:FB];

	assign dv_valid[0] = valid_s2;
	assign dv_rem[0]   = rem_s2;
	assign dv_span[0]  = span_s2;
	assign dv_quo[0]   = '0;
	assign dv_side[0]  = side_s2;

	for (genvar k = 0; k < FB; k++) begin : g_div
		bli_div_stage #(
			.FRACTION_BITS(FB)
		) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.cur_valid(dv_valid[k]),
			.cur_rem  (dv_rem[k]),
			.cur_span (dv_span[k]),
			.cur_quo  (dv_quo[k]),
			.cur_side (dv_side[k]),
			.nxt_valid(dv_valid[k+1]),
			.nxt_rem  (dv_rem[k+1]),
			.nxt_span (dv_span[k+1]),
			.nxt_quo  (dv_quo[k+1]),
			.nxt_side (dv_side[k+1])
		);
	end

	// ---------------- stage 3: fraction times stat difference ----------------
	logic                     valid_s3;
	logic signed [PROD_W-1:0] product_s3;
	logic [FB-1:0]            quo_s3;
	side_t                    side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= dv_valid[FB];
		end
	end

	// sign-extend both operands to the full product width before multiplying
	always_ff @(posedge clk) begin
		if (en) begin
			product_s3 <= PROD_W'($signed({1'b0, dv_quo[FB]})) * PROD_W'(dv_side[FB].diff);
			quo_s3     <= dv_quo[FB];
			side_s3    <= dv_side[FB];
		end
	end

	// ---------------- stage 4: floor shift, add, output register ----------------
	logic signed [PROD_W-1:0] shifted;
	logic signed [IN_W-1:0]   value_c;
	logic [FB:0]              frac_c;
	logic                     valid_s4;
	logic signed [IN_W-1:0]   value_s4;
	logic [FRAC_W-1:0]        frac_s4;
	logic [SEG_W-1:0]         seg_s4;

	// arithmetic shift rounds toward minus infinity
	assign shifted = product_s3 >>> FB;

	always_comb begin
		case (side_s3.mode)
			MODE_INTERP: begin
				value_c = side_s3.s_lo + shifted[IN_W-1:0];
				frac_c  = {1'b0, quo_s3};
			end
			MODE_HIGH: begin
				value_c = side_s3.s_lo;
				frac_c  = FRAC_ONE;
			end
			default: begin
				value_c = side_s3.s_lo;
				frac_c  = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			value_s4 <= value_c;
			frac_s4  <= FRAC_W'(frac_c);
			seg_s4   <= side_s3.seg;
		end
	end

	assign out_valid    = valid_s4;
	assign value_out    = value_s4;
	assign fraction_out = frac_s4;
	assign segment_out  = seg_s4;

	// ---------------- assertions ----------------
	// a refused output beat must back-pressure the input
	a_stall_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("output refused but input not stalled");

	// the divider remainder never reaches the span
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		dv_valid[FB] |-> dv_rem[FB] < dv_span[FB])
		else $error("divider remainder out of range");

	// below the first breakpoint the fraction is zero
	a_low_frac: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && segment_out == '0 |-> fraction_out == '0)
		else $error("nonzero fraction below first breakpoint");

	// segment never exceeds the point count
	a_seg_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> segment_out <= SEG_TOP)
		else $error("segment index out of range");

	// a beat entering the last pipeline stage shows up on the output next cycle
	a_out_follow: assert property (@(posedge clk) disable iff (!arst_n)
		en && valid_s3 |=> out_valid)
		else $error("result lost at output stage");

endmodule
